// ===== hw/rtl/piv_pkg.sv =====
// Shared types, constants and arithmetic helpers for the point-in-volume test.
package piv_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RotW   = 16;
  localparam int unsigned LenW   = 31;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned EntW   = 30;
  localparam int unsigned MulW   = 63;
  localparam int unsigned LocW   = 37;
  localparam int unsigned SqInW  = 38;
  localparam int unsigned SqW    = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    SHAPE_BOX      = 3'd0,
    SHAPE_SPHERE   = 3'd1,
    SHAPE_CAPSULE  = 3'd2,
    SHAPE_CYLINDER = 3'd3,
    SHAPE_PLANE    = 3'd4
  } shape_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHAPE_KIND    = 3'd0,
    CFG_HALF_EXTENT_X = 3'd1,
    CFG_HALF_EXTENT_Y = 3'd2,
    CFG_HALF_EXTENT_Z = 3'd3,
    CFG_SPHERE_RADIUS = 3'd4,
    CFG_ROUND_RADIUS  = 3'd5,
    CFG_HALF_HEIGHT   = 3'd6
  } cfg_idx_e;

  // Reset value of every length register: 0.5 in Q16.16.
  localparam logic [LenW-1:0] LenReset = 31'd32768;

  // Saturate a matrix entry to [-1.0, 1.0] in Q2.28.
  function automatic logic signed [EntW-1:0] sat_entry(input logic signed [34:0] v);
    logic signed [34:0] one_p;
    logic signed [34:0] one_n;
    one_p = 35'sd268435456;
    one_n = -35'sd268435456;
    if (v > one_p) begin
      return EntW'(one_p);
    end else if (v < one_n) begin
      return EntW'(one_n);
    end
    return EntW'(v);
  endfunction

  // Square of a signed value, saturating when the magnitude reaches 2^32.
  function automatic logic [SqW-1:0] sq_sat(input logic signed [SqInW-1:0] v);
    logic [SqInW-1:0] a;
    a = v[SqInW-1] ? SqInW'(-v) : SqInW'(v);
    if (a[SqInW-1:32] != '0) begin
      return '1;
    end
    return SqW'(a[31:0]) * SqW'(a[31:0]);
  endfunction

  // Unsigned add that sticks at all ones on overflow.
  function automatic logic [SqW-1:0] add_sat(input logic [SqW-1:0] a, input logic [SqW-1:0] b);
    logic [SqW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SqW] ? '1 : s[SqW-1:0];
  endfunction

endpackage

// ===== hw/rtl/piv_in_if.sv =====
// Input channel: one query beat with positions, rotation and the other-sphere data.
interface piv_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [31:0]          object_x;
  logic signed [31:0]          object_y;
  logic signed [31:0]          object_z;
  logic signed [31:0]          area_x;
  logic signed [31:0]          area_y;
  logic signed [31:0]          area_z;
  logic signed [15:0]          rot_w;
  logic signed [15:0]          rot_x;
  logic signed [15:0]          rot_y;
  logic signed [15:0]          rot_z;
  logic                        other_is_sphere_area;
  logic [30:0]                 other_radius;

  modport source (output valid, object_x, object_y, object_z, area_x, area_y, area_z,
                  rot_w, rot_x, rot_y, rot_z, other_is_sphere_area, other_radius,
                  input ready);
  modport sink (input valid, object_x, object_y, object_z, area_x, area_y, area_z,
                rot_w, rot_x, rot_y, rot_z, other_is_sphere_area, other_radius,
                output ready);
endinterface

// Output channel: one result beat.
interface piv_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ===== hw/rtl/piv_rotate.sv =====
// Four-stage pipeline that moves the object offset into the area's local frame.
module piv_rotate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [piv_pkg::CoordW-1:0]     obj_i   [3],
  input  logic signed [piv_pkg::CoordW-1:0]     area_i  [3],
  input  logic signed [piv_pkg::RotW-1:0]       quat_i  [4],
  output logic                                  valid_o,
  output logic signed [piv_pkg::DiffW-1:0]      diff_o  [3],
  output logic signed [piv_pkg::LocW-1:0]       loc_o   [3]
);
  import piv_pkg::*;

  logic [3:0] valid_q;

  logic signed [DiffW-1:0] d1_q [3];
  logic signed [DiffW-1:0] d2_q [3];
  logic signed [DiffW-1:0] d3_q [3];
  logic signed [DiffW-1:0] d4_q [3];

  // Quaternion products: xx yy zz xy xz yz wx wy wz.
  logic signed [ProdW-1:0] p_q [9];
  logic signed [EntW-1:0]  ent_q [9];
  logic signed [EntW-1:0]  ent_d [9];
  logic signed [MulW-1:0]  mul_q [9];
  logic signed [LocW-1:0]  loc_q [3];

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Matrix entries from the quaternion products, row-major order.
  always_comb begin
    ent_d[0] = sat_entry(35'sd268435456 - ((35'(p_q[1]) + 35'(p_q[2])) <<< 1));
    ent_d[1] = sat_entry((35'(p_q[3]) - 35'(p_q[8])) <<< 1);
    ent_d[2] = sat_entry((35'(p_q[4]) + 35'(p_q[7])) <<< 1);
    ent_d[3] = sat_entry((35'(p_q[3]) + 35'(p_q[8])) <<< 1);
    ent_d[4] = sat_entry(35'sd268435456 - ((35'(p_q[0]) + 35'(p_q[2])) <<< 1));
    ent_d[5] = sat_entry((35'(p_q[5]) - 35'(p_q[6])) <<< 1);
    ent_d[6] = sat_entry((35'(p_q[4]) - 35'(p_q[7])) <<< 1);
    ent_d[7] = sat_entry((35'(p_q[5]) + 35'(p_q[6])) <<< 1);
    ent_d[8] = sat_entry(35'sd268435456 - ((35'(p_q[0]) + 35'(p_q[1])) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 1: offset and quaternion products.
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= DiffW'(obj_i[i]) - DiffW'(area_i[i]);
      end
      p_q[0] <= quat_i[1] * quat_i[1];
      p_q[1] <= quat_i[2] * quat_i[2];
      p_q[2] <= quat_i[3] * quat_i[3];
      p_q[3] <= quat_i[1] * quat_i[2];
      p_q[4] <= quat_i[1] * quat_i[3];
      p_q[5] <= quat_i[2] * quat_i[3];
      p_q[6] <= quat_i[0] * quat_i[1];
      p_q[7] <= quat_i[0] * quat_i[2];
      p_q[8] <= quat_i[0] * quat_i[3];
      // Stage 2: saturated matrix entries.
      d2_q  <= d1_q;
      ent_q <= ent_d;
      // Stage 3: transposed matrix times offset, one product per entry.
      d3_q <= d2_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mul_q[r*3+c] <= MulW'(ent_q[c*3+r]) * MulW'(d2_q[c]);
        end
      end
      // Stage 4: row sums, floor-shifted back to Q16.16.
      d4_q <= d3_q;
      for (int r = 0; r < 3; r++) begin
        loc_q[r] <= LocW'((65'(mul_q[r*3]) + 65'(mul_q[r*3+1]) + 65'(mul_q[r*3+2])) >>> 28);
      end
    end
  end

  assign valid_o = valid_q[3];
  assign diff_o  = d4_q;
  assign loc_o   = loc_q;

endmodule

// ===== hw/rtl/point_in_volume_test.sv =====
// Top level of the point-in-volume test: local-frame transform, squares and shape test.
// The pipeline has six register stages: four in the transform, then squares and the shape decision.
// Throughput: one beat per cycle unless the output stalls; the six-stage pipeline advances as a whole.
// The pipeline holds when the output register is full and not taken.
// Reset clears all valid bits and loads shape box with every length at 0.5.
module point_in_volume_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  piv_in_if.sink                            in_s,
  piv_out_if.source                         out_s,
  input  logic                              cfg_we_i,
  input  logic [piv_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [piv_pkg::LenW-1:0]          cfg_data_i
);
  import piv_pkg::*;

  logic en;

  // Configuration registers.
  logic [2:0]      shape_q;
  logic [LenW-1:0] hx_q, hy_q, hz_q, srad_q, rrad_q, hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_BOX;
      hx_q    <= LenReset;
      hy_q    <= LenReset;
      hz_q    <= LenReset;
      srad_q  <= LenReset;
      rrad_q  <= LenReset;
      hh_q    <= LenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SHAPE_KIND:    shape_q <= cfg_data_i[2:0];
        CFG_HALF_EXTENT_X: hx_q    <= cfg_data_i;
        CFG_HALF_EXTENT_Y: hy_q    <= cfg_data_i;
        CFG_HALF_EXTENT_Z: hz_q    <= cfg_data_i;
        CFG_SPHERE_RADIUS: srad_q  <= cfg_data_i;
        CFG_ROUND_RADIUS:  rrad_q  <= cfg_data_i;
        CFG_HALF_HEIGHT:   hh_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished beat waits on the output.
  assign en         = !out_s.valid || out_s.ready;
  assign in_s.ready = en;

  logic signed [CoordW-1:0] obj  [3];
  logic signed [CoordW-1:0] area [3];
  logic signed [RotW-1:0]   quat [4];
  logic                     rot_valid;
  logic signed [DiffW-1:0]  diff [3];
  logic signed [LocW-1:0]   loc  [3];

  assign obj  = '{in_s.object_x, in_s.object_y, in_s.object_z};
  assign area = '{in_s.area_x, in_s.area_y, in_s.area_z};
  assign quat = '{in_s.rot_w, in_s.rot_x, in_s.rot_y, in_s.rot_z};

  piv_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_s.valid && en),
    .obj_i   (obj),
    .area_i  (area),
    .quat_i  (quat),
    .valid_o (rot_valid),
    .diff_o  (diff),
    .loc_o   (loc)
  );

  // Delay line for the other-sphere fields alongside the transform stages.
  logic            oth_q  [4];
  logic [LenW-1:0] orad_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      oth_q[0]  <= in_s.other_is_sphere_area;
      orad_q[0] <= in_s.other_radius;
      for (int i = 1; i < 4; i++) begin
        oth_q[i]  <= oth_q[i-1];
        orad_q[i] <= orad_q[i-1];
      end
    end
  end

  // Stage 5: squares, bound checks and squared radii.
  logic            v5_q;
  logic [SqW-1:0]  sql_q [3];
  logic [SqW-1:0]  sqd_q [3];
  logic [SqW-1:0]  squp_q, sqdn_q, rs_q, rc_q, rr_q;
  logic            oth5_q, box_q, mid_q, above_q;
  logic signed [SqInW-1:0] hh_s, hx_s, hy_s, hz_s;
  logic signed [SqInW-1:0] ly_s;
  logic [LenW:0]           rsum;

  always_comb begin
    hh_s = SqInW'($signed({1'b0, hh_q}));
    hx_s = SqInW'($signed({1'b0, hx_q}));
    hy_s = SqInW'($signed({1'b0, hy_q}));
    hz_s = SqInW'($signed({1'b0, hz_q}));
    ly_s = SqInW'(loc[1]);
    rsum = {1'b0, srad_q} + {1'b0, orad_q[3]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sql_q[i] <= sq_sat(SqInW'(loc[i]));
        sqd_q[i] <= sq_sat(SqInW'(diff[i]));
      end
      squp_q  <= sq_sat(ly_s - hh_s);
      sqdn_q  <= sq_sat(ly_s + hh_s);
      rs_q    <= SqW'(srad_q) * SqW'(srad_q);
      rc_q    <= SqW'(rsum) * SqW'(rsum);
      rr_q    <= SqW'(rrad_q) * SqW'(rrad_q);
      oth5_q  <= oth_q[3];
      box_q   <= SqInW'(loc[0]) >= -hx_s && SqInW'(loc[0]) <= hx_s &&
                 ly_s >= -hy_s && ly_s <= hy_s &&
                 SqInW'(loc[2]) >= -hz_s && SqInW'(loc[2]) <= hz_s;
      mid_q   <= ly_s >= -hh_s && ly_s <= hh_s;
      above_q <= ly_s > hh_s;
    end
  end

  // Stage 6: sums of squares and the shape decision.
  logic           inside_d, inside_q, v6_q;
  logic [SqW-1:0] h2, d2l, d2w;

  always_comb begin
    h2  = add_sat(sql_q[0], sql_q[2]);
    d2l = add_sat(add_sat(sql_q[0], sql_q[1]), sql_q[2]);
    d2w = add_sat(add_sat(sqd_q[0], sqd_q[1]), sqd_q[2]);
    case (shape_q)
      SHAPE_BOX:      inside_d = box_q;
      SHAPE_SPHERE:   inside_d = oth5_q ? (d2w <= rc_q) : (d2l <= rs_q);
      SHAPE_CAPSULE: begin
        if (mid_q) begin
          inside_d = h2 <= rr_q;
        end else if (above_q) begin
          inside_d = add_sat(h2, squp_q) <= rr_q;
        end else begin
          inside_d = add_sat(h2, sqdn_q) <= rr_q;
        end
      end
      SHAPE_CYLINDER: inside_d = mid_q && (h2 <= rr_q);
      default:        inside_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v5_q <= rot_valid;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q <= inside_d;
    end
  end

  assign out_s.valid      = v6_q;
  assign out_s.inside_res = inside_q;

  // A held input means a full output register that is not being taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_s.ready |-> (out_s.valid && !out_s.ready))
    else $error("input stalled without a blocked output beat");

  // Plane and unused codes never report containment.
  a_plane_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_s.valid && shape_q >= SHAPE_PLANE) |-> !out_s.inside_res)
    else $error("plane shape reported inside");

  // While stalled the internal stage valid bits do not move.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v5_q) && $stable(rot_valid)))
    else $error("pipeline moved during a stall");

  // An accepted beat at the output leaves the register empty unless stage five refills it.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_s.valid && out_s.ready && !v5_q) |=> !out_s.valid)
    else $error("result beat repeated");

endmodule

// ===== tb/sv/point_in_volume_test_tb.sv =====
// Testbench for the point-in-volume test: directed and random queries checked against a predictor.
module point_in_volume_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import piv_pkg::*;

  typedef struct {
    logic signed [31:0] object_x, object_y, object_z;
    logic signed [31:0] area_x, area_y, area_z;
    logic signed [15:0] rot_w, rot_x, rot_y, rot_z;
    logic               other_is_sphere_area;
    logic [30:0]        other_radius;
  } query_t;

  // Containment predictor with its own copy of the registers and a queue of expected answers.
  class containment_board;
    logic [2:0]  shape_kind;
    logic [30:0] half_x, half_y, half_z, sphere_r, round_r, half_h;
    bit          inside_q[$];
    int          mismatches;

    function new();
      shape_kind = SHAPE_BOX;
      half_x = LenReset; half_y = LenReset; half_z = LenReset;
      sphere_r = LenReset; round_r = LenReset; half_h = LenReset;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [30:0] data);
      case (idx)
        CFG_SHAPE_KIND:    shape_kind = data[2:0];
        CFG_HALF_EXTENT_X: half_x = data;
        CFG_HALF_EXTENT_Y: half_y = data;
        CFG_HALF_EXTENT_Z: half_z = data;
        CFG_SPHERE_RADIUS: sphere_r = data;
        CFG_ROUND_RADIUS:  round_r = data;
        CFG_HALF_HEIGHT:   half_h = data;
        default: ;
      endcase
    endfunction

    static function longint clamp_unit(longint v);
      if (v > (64'sd1 << 28)) return 64'sd1 << 28;
      if (v < -(64'sd1 << 28)) return -(64'sd1 << 28);
      return v;
    endfunction

    static function logic [63:0] square_clip(longint v);
      longint      a;
      logic [63:0] ua;
      a = (v < 0) ? -v : v;
      if (a > 64'sh0_FFFF_FFFF) return '1;
      ua = a;
      return ua * ua;
    endfunction

    static function logic [63:0] sum_clip(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function bit predict(query_t q);
      longint dx, dy, dz, w, x, y, z, lx, ly, lz, hh;
      longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic [63:0] rr, dist2, flat2;
      dx = longint'(q.object_x) - longint'(q.area_x);
      dy = longint'(q.object_y) - longint'(q.area_y);
      dz = longint'(q.object_z) - longint'(q.area_z);
      w = q.rot_w; x = q.rot_x; y = q.rot_y; z = q.rot_z;
      m00 = clamp_unit((64'sd1 << 28) - 2 * (y * y + z * z));
      m01 = clamp_unit(2 * (x * y - w * z));
      m02 = clamp_unit(2 * (x * z + w * y));
      m10 = clamp_unit(2 * (x * y + w * z));
      m11 = clamp_unit((64'sd1 << 28) - 2 * (x * x + z * z));
      m12 = clamp_unit(2 * (y * z - w * x));
      m20 = clamp_unit(2 * (x * z - w * y));
      m21 = clamp_unit(2 * (y * z + w * x));
      m22 = clamp_unit((64'sd1 << 28) - 2 * (x * x + y * y));
      // The transposed matrix applies the conjugate rotation.
      lx = (m00 * dx + m10 * dy + m20 * dz) >>> 28;
      ly = (m01 * dx + m11 * dy + m21 * dz) >>> 28;
      lz = (m02 * dx + m12 * dy + m22 * dz) >>> 28;
      hh = half_h;
      case (shape_kind)
        SHAPE_BOX:
          return lx >= -longint'(half_x) && lx <= longint'(half_x) &&
                 ly >= -longint'(half_y) && ly <= longint'(half_y) &&
                 lz >= -longint'(half_z) && lz <= longint'(half_z);
        SHAPE_SPHERE: begin
          if (q.other_is_sphere_area) begin
            rr = 64'(sphere_r) + 64'(q.other_radius);
            dist2 = sum_clip(sum_clip(square_clip(dx), square_clip(dy)), square_clip(dz));
          end else begin
            rr = 64'(sphere_r);
            dist2 = sum_clip(sum_clip(square_clip(lx), square_clip(ly)), square_clip(lz));
          end
          return dist2 <= rr * rr;
        end
        SHAPE_CAPSULE, SHAPE_CYLINDER: begin
          rr = 64'(round_r) * 64'(round_r);
          flat2 = sum_clip(square_clip(lx), square_clip(lz));
          if (ly >= -hh && ly <= hh) return flat2 <= rr;
          if (shape_kind == SHAPE_CYLINDER) return 0;
          // Past the end of the capsule the nearer cap center counts.
          if (ly > hh) return sum_clip(flat2, square_clip(ly - hh)) <= rr;
          return sum_clip(flat2, square_clip(ly + hh)) <= rr;
        end
        default: return 0;
      endcase
    endfunction

    function void note_query(query_t q);
      inside_q = {inside_q, predict(q)};
    endfunction

    function void check_result(logic inside_res);
      bit want;
      if (inside_q.size() == 0) begin
        $error("inside_res beat %0d arrived with no query waiting", inside_res);
        mismatches++;
        return;
      end
      want = inside_q.pop_front();
      if (inside_res !== want) begin
        $error("inside_res: expected %0d, actual %0d", want, inside_res);
        mismatches++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [30:0] cfg_data = '0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  containment_board board = new();

  piv_in_if  in_if();
  piv_out_if out_if();

  point_in_volume_test dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_s      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random backpressure, applied at the falling edge.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Result beats are checked at the rising edge; the watchdog counts silent cycles.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) board.check_result(out_if.inside_res);
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_query(query_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.object_x = q.object_x; in_if.object_y = q.object_y; in_if.object_z = q.object_z;
    in_if.area_x = q.area_x; in_if.area_y = q.area_y; in_if.area_z = q.area_z;
    in_if.rot_w = q.rot_w; in_if.rot_x = q.rot_x; in_if.rot_y = q.rot_y; in_if.rot_z = q.rot_z;
    in_if.other_is_sphere_area = q.other_is_sphere_area;
    in_if.other_radius = q.other_radius;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_query(q);
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every expected answer is back, plus pipeline slack.
  task automatic drain();
    in_if.valid = 1'b0;
    while (board.inside_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [30:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // A length spread over many scales, with both extremes now and then.
  function automatic logic [30:0] pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 31'($urandom >> $urandom_range(6, 31));
    endcase
  endfunction

  function automatic query_t make_query(int ox, int oy, int oz, int ax, int ay, int az,
                                        int w, int x, int y, int z, bit flag, int rad);
    query_t q;
    q.object_x = ox; q.object_y = oy; q.object_z = oz;
    q.area_x = ax; q.area_y = ay; q.area_z = az;
    q.rot_w = 16'(w); q.rot_x = 16'(x); q.rot_y = 16'(y); q.rot_z = 16'(z);
    q.other_is_sphere_area = flag;
    q.other_radius = 31'(rad);
    return q;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     k;
    q.area_x = $urandom; q.area_y = $urandom; q.area_z = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      // Object near the area so both answers stay common.
      q.area_x = q.area_x >>> $urandom_range(0, 12);
      q.area_y = q.area_y >>> $urandom_range(0, 12);
      q.area_z = q.area_z >>> $urandom_range(0, 12);
      k = $urandom_range(4, 31);
      q.object_x = q.area_x + (32'($urandom) >>> k);
      q.object_y = q.area_y + (32'($urandom) >>> k);
      q.object_z = q.area_z + (32'($urandom) >>> k);
    end else begin
      q.object_x = $urandom; q.object_y = $urandom; q.object_z = $urandom;
    end
    k = $urandom_range(0, 9);
    if (k < 6) begin
      // Unit rotations: identity, quarter and half turns, a generic tilt.
      case ($urandom_range(0, 4))
        0: begin q.rot_w = 16384; q.rot_x = 0; q.rot_y = 0; q.rot_z = 0; end
        1: begin q.rot_w = 11585; q.rot_x = 0; q.rot_y = 0; q.rot_z = 11585; end
        2: begin q.rot_w = 11585; q.rot_x = 11585; q.rot_y = 0; q.rot_z = 0; end
        3: begin q.rot_w = 0; q.rot_x = 0; q.rot_y = 16384; q.rot_z = 0; end
        default: begin q.rot_w = 8192; q.rot_x = 8192; q.rot_y = 8192; q.rot_z = 8192; end
      endcase
      if ($urandom_range(0, 1)) begin
        q.rot_w = -q.rot_w; q.rot_x = -q.rot_x; q.rot_y = -q.rot_y; q.rot_z = -q.rot_z;
      end
    end else begin
      q.rot_w = 16'($urandom); q.rot_x = 16'($urandom);
      q.rot_y = 16'($urandom); q.rot_z = 16'($urandom);
      if (k < 9) begin
        q.rot_w = q.rot_w >>> 1; q.rot_x = q.rot_x >>> 2;
        q.rot_y = q.rot_y >>> 2; q.rot_z = q.rot_z >>> 2;
      end
    end
    q.other_is_sphere_area = $urandom_range(0, 1);
    q.other_radius = ($urandom_range(0, 7) == 0) ? 31'($urandom) : pick_length();
    return q;
  endfunction

  initial begin
    query_t directed[$];
    logic [2:0] shape_plan[12];
    in_if.valid = 1'b0;
    in_if.object_x = '0; in_if.object_y = '0; in_if.object_z = '0;
    in_if.area_x = '0; in_if.area_y = '0; in_if.area_z = '0;
    in_if.rot_w = '0; in_if.rot_x = '0; in_if.rot_y = '0; in_if.rot_z = '0;
    in_if.other_is_sphere_area = 1'b0;
    in_if.other_radius = '0;
    out_if.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed queries under the reset box: bounds, extremes and odd rotations.
    directed = {directed, make_query(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(32768, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(32769, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(0, -32768, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(0, 0, -32769, 0, 0, 0, 16384, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(40000, 0, 0, 0, 0, 0, 11585, 0, 0, 11585, 0, 0)};
    directed = {directed, make_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                     16384, 0, 0, 0, 1, 31'h7FFF_FFFF)};
    directed = {directed, make_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                     -32768, -32768, -32768, -32768, 0, 0)};
    directed = {directed,
                make_query(100, 200, 300, 0, 0, 0, 32767, 32767, 32767, 32767, 1, 0)};
    directed = {directed, make_query(100, -200, 300, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(-1, -1, -1, 0, 0, 0, -16384, 0, 0, 0, 0, 0)};
    directed = {directed, make_query(0, 40000, 0, 0, 0, 0, 11585, 11585, 0, 0, 0, 12345)};
    foreach (directed[i]) send_query(directed[i]);
    drain();

    // Each phase rewrites every register, then runs a batch of queries.
    shape_plan = '{SHAPE_SPHERE, SHAPE_CAPSULE, SHAPE_CYLINDER, SHAPE_PLANE, SHAPE_BOX,
                   3'd7, SHAPE_SPHERE, SHAPE_CAPSULE, SHAPE_CYLINDER, SHAPE_BOX,
                   SHAPE_SPHERE, 3'd5};
    for (int p = 0; p < 12; p++) begin
      write_reg(CFG_SHAPE_KIND, 31'(shape_plan[p]));
      write_reg(CFG_HALF_EXTENT_X, p == 4 ? 31'h7FFF_FFFF : p == 9 ? 31'd0 : pick_length());
      write_reg(CFG_HALF_EXTENT_Y, p == 4 ? 31'h7FFF_FFFF : pick_length());
      write_reg(CFG_HALF_EXTENT_Z, p == 9 ? 31'd0 : pick_length());
      write_reg(CFG_SPHERE_RADIUS, p == 6 ? 31'h7FFF_FFFF : p == 10 ? 31'd0 : pick_length());
      write_reg(CFG_ROUND_RADIUS, p == 7 ? 31'h7FFF_FFFF : p == 8 ? 31'd0 : pick_length());
      write_reg(CFG_HALF_HEIGHT, p == 2 ? 31'd0 : p == 8 ? 31'h7FFF_FFFF : pick_length());
      calm = (p % 4 == 3);
      for (int n = 0; n < 87; n++) begin
        send_query(random_query());
        // Once mid-phase the sender holds off until the pipeline is empty.
        if (p == 5 && n == 40) drain();
      end
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== point_in_volume_test.f =====
hw/rtl/piv_pkg.sv
hw/rtl/piv_in_if.sv
hw/rtl/piv_rotate.sv
hw/rtl/point_in_volume_test.sv
tb/sv/point_in_volume_test_tb.sv
